/* rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion, also checked during reset
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* rtl/nco_mix_pkg.sv */
// Package: widths, sine table and arithmetic helpers of the NCO mixer
`timescale 1ns / 1ps

package nco_mix_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_BITS      = 32;
    localparam int STEP_BITS       = 32;
    localparam int TABLE_ADDR_BITS = 10;

    localparam int QLEN     = 1 << (TABLE_ADDR_BITS - 2);
    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int ACC_BITS  = 2 * SAMPLE_BITS + 2;
    localparam int RND_BITS  = ACC_BITS - SAMPLE_BITS + 1;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] AMP         = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [PHASE_BITS-1:0]         phase_t;
    typedef logic [STEP_BITS-1:0]          step_t;
    typedef logic [TABLE_ADDR_BITS-1:0]    tab_idx_t;
    typedef logic [TABLE_ADDR_BITS-2:0]    quarter_idx_t;
    typedef logic [SAMPLE_BITS-2:0]        quarter_t;
    typedef quarter_t                      quarter_tab_t [0:QLEN];

    // Quarter-turn offset in table index units (cosine lookup)
    localparam tab_idx_t QUARTER_TURN =
        {2'b01, {(TABLE_ADDR_BITS-2){1'b0}}};
    localparam quarter_idx_t QLEN_IDX =
        {1'b1, {(TABLE_ADDR_BITS-2){1'b0}}};

    // Rounding constant and saturation limits
    localparam acc_t ROUND_HALF =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, 1'b1, {(SAMPLE_BITS-2){1'b0}}};
    localparam logic signed [RND_BITS-1:0] SAT_HI =
        {{(RND_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [RND_BITS-1:0] SAT_LO =
        {{(RND_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // One quarter-wave entry: Q30 Taylor series in Horner form
    function automatic quarter_t sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (HALF_PI_Q30 * 64'(k)) >> (TABLE_ADDR_BITS - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd272);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd210);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        v  = (AMP * s + (ONE_Q30 >> 1)) >> 30;
        if (v > AMP)
        begin
            v = AMP;
        end
        return v[SAMPLE_BITS-2:0];
    endfunction

    function automatic quarter_tab_t build_quarter();
        quarter_tab_t tab;
        for (int k = 0; k <= QLEN; k++)
        begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

    localparam quarter_tab_t QUARTER_TAB = build_quarter();

    // Full-turn sine from the quarter table by quadrant symmetry
    function automatic sample_t table_sin(input tab_idx_t idx);
        logic [1:0]   quad;
        quarter_idx_t r;
        quarter_idx_t addr;
        sample_t      mag;
        quad = idx[TABLE_ADDR_BITS-1 -: 2];
        r    = {1'b0, idx[TABLE_ADDR_BITS-3:0]};
        addr = quad[0] ? (QLEN_IDX - r) : r;
        mag  = {1'b0, QUARTER_TAB[addr]};
        return quad[1] ? -mag : mag;
    endfunction

    // Round half up, drop the fraction, clamp to the sample range
    function automatic sample_t round_sat(input acc_t acc);
        acc_t                        biased;
        logic signed [RND_BITS-1:0]  r;
        sample_t                     res;
        biased = acc + ROUND_HALF;
        r      = biased[ACC_BITS-1:SAMPLE_BITS-1];
        if (r > SAT_HI)
        begin
            res = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (r < SAT_LO)
        begin
            res = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            res = r[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/nco_mix_if.sv */
// Interfaces: sample input, mixed output and configuration write channels
`timescale 1ns / 1ps

interface nco_in_if
    import nco_mix_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t in_re;
    sample_t in_im;
    logic    last;

    modport source (output valid, output in_re, output in_im, output last, input ready);
    modport sink   (input valid, input in_re, input in_im, input last, output ready);
endinterface

interface nco_out_if
    import nco_mix_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t out_re;
    sample_t out_im;
    logic    out_last;

    modport source (output valid, output out_re, output out_im, output out_last,
                    input ready);
    modport sink   (input valid, input out_re, input out_im, input out_last,
                    output ready);
endinterface

interface cfg_wr_if
    import nco_mix_pkg::*;
();
    logic  valid;
    logic  ready;
    step_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/complex_nco_mixer.sv */
// Top level: complex NCO mixer, rotates each sample by the accumulated phase
`timescale 1ns / 1ps
//
// Usage
//   samples : complex Q1.15 request (in_re, in_im) with a last flag that
//             closes a block. The phase is zero for the first sample after
//             reset and after every sample flagged last.
//   mixed   : rotated sample (out_re, out_im) and out_last, one per request,
//             in the same order.
//   cfg     : writes the signed 32-bit phase step; always ready. Write it
//             only while no request is in flight.
// Timing
//   One sample per cycle while mixed is not stalled. The table read ends
//   in the input register, then four 16x16 products, then sum, round and
//   saturate, each ending in a register.
// Reset
//   Clears the phase accumulator, the phase step and all stage valid bits.
// Stalls
//   A full stage holds while the next one cannot move; a stalled result
//   stays on mixed until taken, and earlier stages keep filling behind it.
//
module complex_nco_mixer
    import nco_mix_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nco_in_if.sink     samples,
    nco_out_if.source  mixed,
    cfg_wr_if.sink     cfg
);

    phase_t   phase_acc_reg;
    phase_t   phase_acc_next;
    step_t    phase_step_reg;
    tab_idx_t sin_idx;
    tab_idx_t cos_idx;

    logic     v1_reg;
    logic     v2_reg;
    logic     v3_reg;
    logic     rdy1;
    logic     rdy2;
    logic     rdy3;
    logic     in_acc;

    sample_t  re1_reg;
    sample_t  im1_reg;
    sample_t  sin1_reg;
    sample_t  cos1_reg;
    logic     last1_reg;

    prod_t    p_rc_reg;
    prod_t    p_is_reg;
    prod_t    p_rs_reg;
    prod_t    p_ic_reg;
    logic     last2_reg;

    acc_t     acc_re;
    acc_t     acc_im;
    sample_t  out_re_reg;
    sample_t  out_im_reg;
    logic     out_last_reg;

    // Stage readiness: a stage moves when it is empty or its successor moves
    assign rdy3   = !v3_reg || mixed.ready;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign in_acc = samples.valid && rdy1;

    assign samples.ready = rdy1;
    assign cfg.ready     = 1'b1;

    // Table indexes from the top phase bits
    assign sin_idx = phase_acc_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign cos_idx = sin_idx + QUARTER_TURN;

    // Advance the phase, restart it after the last sample of a block
    always_comb
    begin
        if (samples.last)
        begin
            phase_acc_next = '0;
        end
        else
        begin
            phase_acc_next = phase_acc_reg + PHASE_BITS'(signed'(phase_step_reg));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                phase_step_reg <= cfg.data;
            end
            if (in_acc)
            begin
                phase_acc_reg <= phase_acc_next;
            end
            if (rdy1)
            begin
                v1_reg <= samples.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: capture the sample and look up sine and cosine
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            re1_reg   <= samples.in_re;
            im1_reg   <= samples.in_im;
            last1_reg <= samples.last;
            sin1_reg  <= table_sin(sin_idx);
            cos1_reg  <= table_sin(cos_idx);
        end
    end

    // Stage 2: the four partial products
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            p_rc_reg  <= re1_reg * cos1_reg;
            p_is_reg  <= im1_reg * sin1_reg;
            p_rs_reg  <= re1_reg * sin1_reg;
            p_ic_reg  <= im1_reg * cos1_reg;
            last2_reg <= last1_reg;
        end
    end

    // Combine products for the real and imaginary parts
    assign acc_re = ACC_BITS'(p_rc_reg) - ACC_BITS'(p_is_reg);
    assign acc_im = ACC_BITS'(p_rs_reg) + ACC_BITS'(p_ic_reg);

    // Stage 3: round, saturate and hold the result for the receiver
    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            out_re_reg   <= round_sat(acc_re);
            out_im_reg   <= round_sat(acc_im);
            out_last_reg <= last2_reg;
        end
    end

    assign mixed.valid    = v3_reg;
    assign mixed.out_re   = out_re_reg;
    assign mixed.out_im   = out_im_reg;
    assign mixed.out_last = out_last_reg;

endmodule

/* rtl/nco_mix_chk.sv */
// Checker: port-level assertions for the NCO mixer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nco_mix_chk
    import nco_mix_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t out_re,
    input sample_t out_im,
    input logic    out_last
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // Hold a stalled result unchanged
    `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im) && $stable(out_last), "stalled result dropped or changed")

    // A result appearing on an idle output comes from an accepted request that passed the stage registers
    `ASSERT_CLK_RST(a_out_from_req, clk, rst_n, $rose(out_valid) |-> $past(in_acc, 3), "result without matching request")

    // Drain: an idle output with no request still in the stage registers stays idle
    `ASSERT_CLK_RST(a_no_phantom, clk, rst_n, $past(!out_valid) && $past(!in_acc) && $past(!in_acc, 2) && $past(!in_acc, 3) |-> !out_valid, "result invented from an empty pipeline")

    // No result shown during reset
    `ASSERT_CLK(a_reset_idle, clk, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind complex_nco_mixer nco_mix_chk u_nco_mix_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (mixed.valid),
    .out_ready (mixed.ready),
    .out_re    (mixed.out_re),
    .out_im    (mixed.out_im),
    .out_last  (mixed.out_last)
);

/* tb/complex_nco_mixer_tb.sv */
// Testbench for the complex NCO mixer: directed, random and back-pressure tests
`timescale 1ns / 1ps

module complex_nco_mixer_tb;
    import nco_mix_pkg::*;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam longint      FULL_SCALE    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint      NEG_SCALE     = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam longint unsigned UNITY_Q30        = 64'd1 << 30;
    localparam longint unsigned RIGHT_ANGLE_Q30  = 64'd1686629713;

    localparam step_t STEP_ZERO     = 32'h0000_0000;
    localparam step_t STEP_QUARTER  = 32'h4000_0000;
    localparam step_t STEP_MAX_POS  = 32'h7FFF_FFFF;
    localparam step_t STEP_MAX_NEG  = 32'h8000_0000;
    localparam step_t STEP_MINUS_1  = 32'hFFFF_FFFF;
    localparam step_t STEP_PLUS_1   = 32'h0000_0001;

    typedef struct {
        sample_t re;
        sample_t im;
        logic    last;
    } mix_t;

    logic clk;
    logic rst_n;

    nco_in_if  samples_ch ();
    nco_out_if mixed_ch ();
    cfg_wr_if  cfg_ch ();

    complex_nco_mixer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .mixed   (mixed_ch),
        .cfg     (cfg_ch)
    );

    // Oscillator state mirrored from the block
    int     quarter_wave [0:QLEN];
    phase_t nco_phase;
    step_t  nco_step;

    mix_t pending_mix [$];
    int   fault_count;
    int   result_count;
    bit   tx_idle;
    bit   rx_idle;
    int   hold_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // One quarter-wave entry: Q30 Taylor series, truncating at each step
    function automatic int sine_q30(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        longint unsigned d;
        x  = (RIGHT_ANGLE_Q30 * k) / QLEN;
        x2 = (x * x) >> 30;
        t  = UNITY_Q30;
        for (int n = 8; n >= 1; n--)
        begin
            d = longint'((2 * n) * (2 * n + 1));
            t = UNITY_Q30 - (((x2 * t) >> 30) / d);
        end
        s = (x * t) >> 30;
        v = (longint'(FULL_SCALE) * s + (UNITY_Q30 >> 1)) >> 30;
        if (v > FULL_SCALE)
        begin
            v = FULL_SCALE;
        end
        return int'(v);
    endfunction

    // Full-turn sine by quadrant symmetry
    function automatic longint wave_at(tab_idx_t i);
        logic [1:0] quad;
        int         r;
        longint     v;
        quad = i[TABLE_ADDR_BITS-1 -: 2];
        r    = int'(i[TABLE_ADDR_BITS-3:0]);
        v    = quad[0] ? quarter_wave[QLEN - r] : quarter_wave[r];
        return quad[1] ? -v : v;
    endfunction

    // Round half up, drop the fraction and clamp to the sample range
    function automatic sample_t round_clamp(longint acc);
        longint r;
        r = (acc + (longint'(1) << (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
        if (r > FULL_SCALE)
        begin
            r = FULL_SCALE;
        end
        if (r < NEG_SCALE)
        begin
            r = NEG_SCALE;
        end
        return sample_t'(r);
    endfunction

    // Rotate one sample by the current phase, then advance or restart the phase
    function automatic mix_t rotate_sample(sample_t re, sample_t im, logic last);
        tab_idx_t idx;
        longint   s;
        longint   c;
        mix_t     res;
        idx    = nco_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        s      = wave_at(idx);
        c      = wave_at(idx + tab_idx_t'(QLEN));
        res.re   = round_clamp(longint'(re) * c - longint'(im) * s);
        res.im   = round_clamp(longint'(re) * s + longint'(im) * c);
        res.last = last;
        if (last)
        begin
            nco_phase = '0;
        end
        else
        begin
            nco_phase = nco_phase + phase_t'($signed(nco_step));
        end
        return res;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fault_count++;
    endtask

    // Offer one sample request and record its expected result on acceptance
    task automatic send_sample(sample_t re, sample_t im, logic last);
        int gap;
        bit taken;
        gap   = tx_idle ? $urandom_range(0, 6) : 0;
        taken = 1'b0;
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.in_re <= re;
        samples_ch.in_im <= im;
        samples_ch.last  <= last;
        while (!taken)
        begin
            @(negedge clk);
            taken = samples_ch.ready;
            @(posedge clk);
        end
        pending_mix.push_back(rotate_sample(re, im, last));
    endtask

    // Write the phase step once the pipeline has drained
    task automatic write_phase_step(step_t value);
        bit taken;
        taken = 1'b0;
        samples_ch.valid <= 1'b0;
        while (pending_mix.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ch.ready;
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        nco_step = value;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0: return sample_t'(NEG_SCALE);
            1: return sample_t'(FULL_SCALE);
            2: return '0;
            3: return sample_t'($signed($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Phase zero: exact halfway rounding and sample extremes
    task automatic test_zero_phase();
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 16'sh8000, 1'b0);
        send_sample(16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sh4000, -16'sh4000, 1'b0);
        send_sample(-16'sh4000, 16'sh4000, 1'b0);
        send_sample(16'sh0000, 16'sh0000, 1'b1);
        send_sample(16'sh0001, -16'sh0001, 1'b1);
    endtask

    // Quarter-turn step walks the four quadrants
    task automatic test_quarter_turns();
        write_phase_step(STEP_QUARTER);
        send_sample(16'sh7FFF, 16'sh0000, 1'b0);
        send_sample(16'sh0000, 16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 16'sh8000, 1'b0);
        send_sample(16'sh3039, -16'sh5BA0, 1'b1);
    endtask

    // Largest steps both ways and a step of minus one: the accumulator wraps silently
    task automatic test_step_extremes();
        write_phase_step(STEP_MAX_POS);
        repeat (4) send_sample(16'sh7FFF, 16'sh8000, 1'b0);
        write_phase_step(STEP_MAX_NEG);
        send_sample(16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 16'sh8000, 1'b0);
        send_sample(16'sh4000, 16'sh4000, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
        write_phase_step(STEP_MINUS_1);
        send_sample(16'sh1234, 16'shEDCB, 1'b0);
        send_sample(16'sh7FFF, 16'sh0000, 1'b0);
        send_sample(16'sh0000, 16'sh8000, 1'b1);
    endtask

    // Random blocks under several step settings and idling patterns
    task automatic test_random_blocks();
        int    remaining;
        int    len;
        step_t step;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                1: step = STEP_ZERO;
                2: step = STEP_PLUS_1;
                3: step = STEP_MINUS_1;
                4: step = STEP_MAX_POS;
                5: step = STEP_MAX_NEG;
                6: step = step_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
                default: step = $urandom;
            endcase
            write_phase_step(step);
            tx_idle   = (ph % 4 == 0) || (ph % 4 == 2);
            rx_idle   = (ph % 4 == 0) || (ph % 4 == 3);
            remaining = 155;
            while (remaining > 0)
            begin
                len = $urandom_range(1, 40);
                if (len > remaining)
                begin
                    len = remaining;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    // Drop in a stray sample with a random last flag
                    send_sample(pick_sample(), pick_sample(), $urandom_range(0, 1));
                    len = 1;
                end
                else
                begin
                    for (int i = 0; i < len; i++)
                    begin
                        send_sample(pick_sample(), pick_sample(), i == len - 1);
                    end
                end
                remaining -= len;
            end
        end
    endtask

    // Hold off the receiver while requests keep coming, so the block fills
    task automatic test_backpressure();
        write_phase_step($urandom);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        hold_left <= 80;
        for (int i = 0; i < 40; i++)
        begin
            send_sample(pick_sample(), pick_sample(), $urandom_range(0, 15) == 0);
        end
        tx_idle = 1'b1;
    endtask

    // Count down the receiver hold-off
    initial
    begin
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Take each result and compare it with the oldest expectation
    initial
    begin : result_checker
        int      stall;
        bit      got;
        sample_t got_re;
        sample_t got_im;
        logic    got_last;
        mix_t    want;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 6) : 0;
            got   = 1'b0;
            if (stall > 0 || hold_left > 0)
            begin
                mixed_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_left > 0)
                begin
                    @(posedge clk);
                end
            end
            mixed_ch.ready <= 1'b1;
            while (!got)
            begin
                @(negedge clk);
                got      = mixed_ch.valid;
                got_re   = mixed_ch.out_re;
                got_im   = mixed_ch.out_im;
                got_last = mixed_ch.out_last;
                @(posedge clk);
            end
            result_count++;
            if (pending_mix.size() == 0)
            begin
                report_error($sformatf("result %0d arrived with nothing expected",
                                       result_count));
            end
            else
            begin
                want = pending_mix.pop_front();
                if (got_re !== want.re)
                begin
                    report_error($sformatf("result %0d out_re: got %0d, want %0d",
                                           result_count, got_re, want.re));
                end
                if (got_im !== want.im)
                begin
                    report_error($sformatf("result %0d out_im: got %0d, want %0d",
                                           result_count, got_im, want.im));
                end
                if (got_last !== want.last)
                begin
                    report_error($sformatf("result %0d out_last: got %0b, want %0b",
                                           result_count, got_last, want.last));
                end
            end
        end
    end

    // Abort when no request moves on any channel for too long
    initial
    begin : stall_watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((samples_ch.valid && samples_ch.ready) || (mixed_ch.valid && mixed_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sequence the tests
    initial
    begin
        for (int k = 0; k <= QLEN; k++)
        begin
            quarter_wave[k] = sine_q30(k);
        end
        nco_phase        = '0;
        nco_step         = '0;
        fault_count      = 0;
        result_count     = 0;
        tx_idle          = 1'b1;
        rx_idle          = 1'b1;
        rst_n            = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.in_re = '0;
        samples_ch.in_im = '0;
        samples_ch.last  = 1'b0;
        mixed_ch.ready   = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_phase();
        test_quarter_turns();
        test_step_extremes();
        test_random_blocks();
        test_backpressure();

        // Drain outstanding results, then allow for stragglers
        samples_ch.valid <= 1'b0;
        while (pending_mix.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
